// ===== design/dleu_pkg.sv =====
package dleu_pkg;

	localparam int unsigned AXES = 3;

	localparam logic [2:0] REG_E_GAIN          = 3'd0;
	localparam logic [2:0] REG_CURL_GAIN       = 3'd1;
	localparam logic [2:0] REG_CURRENT_GAIN    = 3'd2;
	localparam logic [2:0] REG_POLAR_GAIN      = 3'd3;
	localparam logic [2:0] REG_PREV_POLAR_GAIN = 3'd4;
	localparam logic [2:0] REG_DRUDE_PAIR      = 3'd5;
	localparam logic [2:0] REG_LORENTZ_DRIVE   = 3'd6;
	localparam logic [2:0] REG_LORENTZ_PAIR    = 3'd7;

	localparam logic signed [31:0] E_GAIN_RESET = 32'sh1000_0000;

	typedef logic signed [31:0] q_t;
	typedef logic signed [63:0] prod_t;

	// State entry for one cell component: Drude current, polarization, previous one.
	typedef struct packed {
		logic signed [31:0] j;
		logic signed [31:0] p;
		logic signed [31:0] p1;
	} cell_state_t;

	// Round a Q4.28 x Q8.24 product to Q12.24 (floor after adding half), 36 bits wide.
	function automatic logic signed [35:0] rnd(input prod_t p);
		logic signed [64:0] t;
		begin
			t = 65'(signed'(p)) + 65'sd134217728;
			return t[63:28];
		end
	endfunction

	function automatic q_t sat(input logic signed [39:0] v);
		begin
			if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
			else if (v < -40'sh0080000000) return 32'sh80000000;
			else return v[31:0];
		end
	endfunction

endpackage

// ===== design/dleu_ram.sv =====
module dleu_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 12288
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/drude_lorentz_efield_update_unit.sv =====
// Drude-Lorentz E-field update unit. Takes one cell component item per clock
// (start while busy is low). Busy is high during the clearing pass after
// reset, in which configuration writes are still taken, and while the
// offered item's state entry still belongs to an item in stages 1..6.
// Each item yields exactly one result, shown for one cycle with done high;
// done is registered from stage 6, and the receiver cannot stall. Rate is
// one item per cycle as long as no item touches an entry still held by an
// item in stages 1..6, set by the state memory that is read at acceptance
// and written back at the end of stage 6.
// Cells beyond CELLS-1 read zero state and leave memory untouched.
module drude_lorentz_efield_update_unit
	import dleu_pkg::*;
#(
	parameter int unsigned CELLS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] cell_index,
	input  logic [1:0]  axis,
	input  logic signed [31:0] e_old,
	input  logic signed [31:0] curl_pos_diff,
	input  logic signed [31:0] curl_neg_diff,
	input  logic signed [31:0] stretch_pos,
	input  logic signed [31:0] stretch_neg,
	output logic        done,
	output logic [11:0] out_cell_index,
	output logic [1:0]  out_axis,
	output logic signed [31:0] e_new
);
	localparam int unsigned DEPTH = CELLS * AXES;
	localparam int unsigned AW = $clog2(DEPTH);

	// configuration
	q_t e_gain_q, curl_gain_q, current_gain_q, polar_gain_q, prev_polar_gain_q;
	q_t lorentz_drive_q;
	logic [63:0] drude_pair_q, lorentz_pair_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_gain_q <= E_GAIN_RESET;
			curl_gain_q <= '0;
			current_gain_q <= '0;
			polar_gain_q <= '0;
			prev_polar_gain_q <= '0;
			drude_pair_q <= '0;
			lorentz_drive_q <= '0;
			lorentz_pair_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_E_GAIN:          e_gain_q <= cfg_data[31:0];
				REG_CURL_GAIN:       curl_gain_q <= cfg_data[31:0];
				REG_CURRENT_GAIN:    current_gain_q <= cfg_data[31:0];
				REG_POLAR_GAIN:      polar_gain_q <= cfg_data[31:0];
				REG_PREV_POLAR_GAIN: prev_polar_gain_q <= cfg_data[31:0];
				REG_DRUDE_PAIR:      drude_pair_q <= cfg_data;
				REG_LORENTZ_DRIVE:   lorentz_drive_q <= cfg_data[31:0];
				REG_LORENTZ_PAIR:    lorentz_pair_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clearing pass
	logic [AW-1:0] clr_addr_q;
	logic          clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) clr_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// stage 0: address
	logic          acc;
	logic [1:0]    ax_sel;
	logic          ok_in;
	logic [AW-1:0] addr_in;
	assign acc = start && !busy;
	assign ax_sel = (axis == 2'd3) ? 2'd2 : axis;
	assign ok_in = 32'(cell_index) < CELLS;
	assign addr_in = AW'(32'(cell_index) * AXES + 32'(ax_sel));

	// pipeline control and payload
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6;
	logic [AW-1:0] a_s1, a_s2, a_s3, a_s4, a_s5, a_s6;
	logic [11:0] ci_s1, ci_s2, ci_s3, ci_s4, ci_s5;
	logic [1:0]  ax_s1, ax_s2, ax_s3, ax_s4, ax_s5;
	q_t eo_s1, eo_s2, eo_s3, eo_s4;
	q_t dp_s1, dn_s1, sp_s1, sn_s1;

	// Hold an item whose entry still belongs to an item in stages 1..6: that
	// write-back lands at the end of stage 6, so the read must come after it.
	logic hz;
	assign hz = ok_in && (
		(v_s1 && ok_s1 && a_s1 == addr_in) || (v_s2 && ok_s2 && a_s2 == addr_in) ||
		(v_s3 && ok_s3 && a_s3 == addr_in) || (v_s4 && ok_s4 && a_s4 == addr_in) ||
		(v_s5 && ok_s5 && a_s5 == addr_in) || (v_s6 && ok_s6 && a_s6 == addr_in));
	assign busy = clr_q || hz;

	// state write-back from stage 6
	cell_state_t wb_s6;
	cell_state_t rd_data;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	cell_state_t mem_wdata;
	assign mem_we = clr_q || (v_s6 && ok_s6);
	assign mem_waddr = clr_q ? clr_addr_q : a_s6;
	assign mem_wdata = clr_q ? cell_state_t'('0) : wb_s6;

	dleu_ram #(.WIDTH($bits(cell_state_t)), .DEPTH(DEPTH)) u_state (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(addr_in), .rdata(rd_data)
	);

	// stage 1: state arrives from memory, curl products
	cell_state_t st_rd;
	cell_state_t st_s2;
	assign st_rd = ok_s1 ? rd_data : cell_state_t'('0);

	prod_t mp_s2, mn_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			v_s1 <= acc; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= ok_in; a_s1 <= addr_in; ci_s1 <= cell_index; ax_s1 <= axis;
		eo_s1 <= e_old; dp_s1 <= curl_pos_diff; dn_s1 <= curl_neg_diff;
		sp_s1 <= stretch_pos; sn_s1 <= stretch_neg;
		ok_s2 <= ok_s1; a_s2 <= a_s1; ci_s2 <= ci_s1; ax_s2 <= ax_s1; eo_s2 <= eo_s1;
		ok_s3 <= ok_s2; a_s3 <= a_s2; ci_s3 <= ci_s2; ax_s3 <= ax_s2; eo_s3 <= eo_s2;
		ok_s4 <= ok_s3; a_s4 <= a_s3; ci_s4 <= ci_s3; ax_s4 <= ax_s3; eo_s4 <= eo_s3;
		ok_s5 <= ok_s4; a_s5 <= a_s4; ci_s5 <= ci_s4; ax_s5 <= ax_s4;
		ok_s6 <= ok_s5; a_s6 <= a_s5;
		st_s2 <= st_rd;
		mp_s2 <= sp_s1 * dp_s1;
		mn_s2 <= sn_s1 * dn_s1;
	end

	// stage 2: form the curl, advance the state
	q_t curl_s3;
	cell_state_t st_s3;
	always_ff @(posedge clk) begin
		curl_s3 <= sat(40'(rnd(mp_s2)) - 40'(rnd(mn_s2)));
		st_s3 <= st_s2;
	end

	// stage 3: e_new and state products
	prod_t pe_s4, pc_s4, pj_s4, pp_s4, pq_s4;
	prod_t ja_s4, pt_s4, pr_s4, bo_s4, zo_s4;
	cell_state_t st_s4;
	always_ff @(posedge clk) begin
		pe_s4 <= e_gain_q * eo_s3;
		pc_s4 <= curl_gain_q * curl_s3;
		pj_s4 <= current_gain_q * st_s3.j;
		pp_s4 <= polar_gain_q * st_s3.p;
		pq_s4 <= prev_polar_gain_q * st_s3.p1;
		ja_s4 <= signed'(drude_pair_q[63:32]) * st_s3.j;
		pt_s4 <= signed'(lorentz_pair_q[63:32]) * st_s3.p;
		pr_s4 <= signed'(lorentz_pair_q[31:0]) * st_s3.p1;
		bo_s4 <= signed'(drude_pair_q[31:0]) * eo_s3;
		zo_s4 <= lorentz_drive_q * eo_s3;
		st_s4 <= st_s3;
	end

	// stage 4: sum for e_new, partial sums for the state
	q_t en_s5;
	logic signed [39:0] jpart_s5, ppart_s5;
	q_t p_s5;
	always_ff @(posedge clk) begin
		en_s5 <= sat(40'(rnd(pe_s4)) + 40'(rnd(pc_s4)) + 40'(rnd(pj_s4))
			+ 40'(rnd(pp_s4)) + 40'(rnd(pq_s4)));
		jpart_s5 <= 40'(rnd(ja_s4)) + 40'(rnd(bo_s4));
		ppart_s5 <= 40'(rnd(zo_s4)) + 40'(rnd(pt_s4)) - 40'(rnd(pr_s4));
		p_s5 <= st_s4.p;
	end

	// stage 5: products on e_new
	prod_t be_s6, ze_s6;
	logic signed [39:0] jpart_s6, ppart_s6;
	q_t en_s6, p_s6;
	always_ff @(posedge clk) begin
		be_s6 <= signed'(drude_pair_q[31:0]) * en_s5;
		ze_s6 <= lorentz_drive_q * en_s5;
		jpart_s6 <= jpart_s5; ppart_s6 <= ppart_s5;
		en_s6 <= en_s5; p_s6 <= p_s5;
	end

	// stage 6: final state
	always_comb begin
		wb_s6.j = sat(jpart_s6 + 40'(rnd(be_s6)));
		wb_s6.p = sat(ppart_s6 + 40'(rnd(ze_s6)));
		wb_s6.p1 = p_s6;
	end

	// result
	logic        done_q;
	logic [11:0] oci_q;
	logic [1:0]  oax_q;
	q_t          oen_q;
	logic [11:0] ci_s6; logic [1:0] ax_s6;
	always_ff @(posedge clk) begin
		ci_s6 <= ci_s5; ax_s6 <= ax_s5;
		oci_q <= ci_s6; oax_q <= ax_s6; oen_q <= en_s6;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= v_s6;
	end
	assign done = done_q;
	assign out_cell_index = oci_q;
	assign out_axis = oax_q;
	assign e_new = oen_q;

	a_no_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |=> !done) else $error("result during clearing pass");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |=> done) else $error("lost result");
	a_no_write_oob: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !ok_s6 && !clr_q) |-> !mem_we) else $error("out of range write");
endmodule

// ===== tb/drude_lorentz_efield_update_unit_test.sv =====
`timescale 1ns / 1ps

module drude_lorentz_efield_update_unit_test
	import dleu_pkg::*;
();

	localparam int unsigned NCELLS = 4096;
	localparam int unsigned PIPE_DEPTH = 6;
	localparam longint CYCLE_LIMIT = 200000;

	// Saturated Q8.24 value and Q4.28 scaled multiply.
	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] scale_mul(input logic signed [31:0] c,
			input logic signed [31:0] v);
		logic signed [63:0] p;
		p = 64'(c) * 64'(v) + 64'sd134217728;
		return p >>> 28;
	endfunction

	typedef struct {
		logic [11:0] cidx;
		logic [1:0]  ax;
		logic signed [31:0] e;
	} efield_result_t;

	class efield_scoreboard;
		logic [63:0] regs [8];
		logic signed [31:0] cur_j [NCELLS*3];
		logic signed [31:0] cur_p [NCELLS*3];
		logic signed [31:0] cur_p1 [NCELLS*3];
		efield_result_t pending_e[$];
		int errors;

		function new();
			foreach (regs[i]) regs[i] = 0;
			regs[REG_E_GAIN] = 64'(E_GAIN_RESET);
			foreach (cur_j[i]) begin
				cur_j[i] = 0;
				cur_p[i] = 0;
				cur_p1[i] = 0;
			end
			errors = 0;
		endfunction

		function void note_item(logic [11:0] cidx, logic [1:0] ax, logic signed [31:0] eo,
				logic signed [31:0] dp, logic signed [31:0] dn,
				logic signed [31:0] sp, logic signed [31:0] sn);
			logic ok;
			int idx;
			logic signed [31:0] j, p, p1, curl, en, a, b, z, t, r;
			efield_result_t res;
			ok = cidx < NCELLS;
			idx = ok ? cidx * 3 + (ax > 2 ? 2 : ax) : 0;
			j = ok ? cur_j[idx] : 0;
			p = ok ? cur_p[idx] : 0;
			p1 = ok ? cur_p1[idx] : 0;
			a = regs[REG_DRUDE_PAIR][63:32];
			b = regs[REG_DRUDE_PAIR][31:0];
			z = regs[REG_LORENTZ_DRIVE][31:0];
			t = regs[REG_LORENTZ_PAIR][63:32];
			r = regs[REG_LORENTZ_PAIR][31:0];
			curl = clamp32(scale_mul(sp, dp) - scale_mul(sn, dn));
			en = clamp32(scale_mul(regs[REG_E_GAIN][31:0], eo)
				+ scale_mul(regs[REG_CURL_GAIN][31:0], curl)
				+ scale_mul(regs[REG_CURRENT_GAIN][31:0], j)
				+ scale_mul(regs[REG_POLAR_GAIN][31:0], p)
				+ scale_mul(regs[REG_PREV_POLAR_GAIN][31:0], p1));
			if (ok) begin
				cur_j[idx] = clamp32(scale_mul(a, j) + scale_mul(b, en) + scale_mul(b, eo));
				cur_p[idx] = clamp32(scale_mul(z, en) + scale_mul(z, eo) + scale_mul(t, p)
					- scale_mul(r, p1));
				cur_p1[idx] = p;
			end
			res.cidx = cidx;
			res.ax = ax;
			res.e = en;
			pending_e.push_back(res);
		endfunction

		function void check_result(logic [11:0] cidx, logic [1:0] ax, logic signed [31:0] e);
			efield_result_t x;
			if (pending_e.size() == 0) begin
				$error("unexpected result cell %0d", cidx);
				errors++;
				return;
			end
			x = pending_e.pop_front();
			if (cidx !== x.cidx) begin
				$error("out_cell_index expected %0d actual %0d", x.cidx, cidx);
				errors++;
			end
			if (ax !== x.ax) begin
				$error("out_axis expected %0d actual %0d", x.ax, ax);
				errors++;
			end
			if (e !== x.e) begin
				$error("e_new expected %0d actual %0d", x.e, e);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = 0;
	logic [63:0] cfg_data = 0;
	logic start = 0;
	logic busy;
	logic [11:0] cell_index = 0;
	logic [1:0] axis = 0;
	logic signed [31:0] e_old = 0, curl_pos_diff = 0, curl_neg_diff = 0;
	logic signed [31:0] stretch_pos = 0, stretch_neg = 0;
	logic done;
	logic [11:0] out_cell_index;
	logic [1:0] out_axis;
	logic signed [31:0] e_new;

	efield_scoreboard board = new();
	int idle_pct = 0;
	longint cycle_count = 0;
	logic [11:0] hot_cells [4];

	drude_lorentz_efield_update_unit uut (.*);

	always #4 clk = ~clk;

	// Watch the cycle budget; a stuck block ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** drude_lorentz_efield_update_unit: FAILED **");
			$finish;
		end
	end

	// Check each strobed result at the edge that ends its cycle.
	always @(posedge clk)
		if (arst_n && done) board.check_result(out_cell_index, out_axis, e_new);

	// Write one register at the next edge, mirroring it in the scoreboard.
	// The caller drops cfg_we after the last write of a batch.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.regs[idx] = val;
	endtask

	// Hold until every expected item has returned, then let the pipe drain.
	task automatic drain();
		while (board.pending_e.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	// Random 32-bit value, often at one of the extremes or near zero.
	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 64)) - 32);
			default: return $urandom;
		endcase
	endfunction

	// Present one item; hold start through busy and drop it only when the next
	// cycle is to stay idle.
	task automatic send_item(input logic [11:0] c, input logic [1:0] a,
			input logic [31:0] eo, input logic [31:0] dp, input logic [31:0] dn,
			input logic [31:0] sp, input logic [31:0] sn);
		start <= 1;
		cell_index <= c;
		axis <= a;
		e_old <= eo;
		curl_pos_diff <= dp;
		curl_neg_diff <= dn;
		stretch_pos <= sp;
		stretch_neg <= sn;
		do @(posedge clk); while (busy);
		board.note_item(c, a, eo, dp, dn, sp, sn);
		if ($urandom_range(1, 100) <= idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic [11:0] c;
		// Reuse a few hot cells so state accumulates and back-to-back hazards hit.
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: c = hot_cells[$urandom_range(0, 3)];
			5: c = 12'($urandom_range(NCELLS - 4, NCELLS - 1));
			default: c = 12'($urandom);
		endcase
		send_item(c, 2'($urandom), pick32(), pick32(), pick32(), pick32(), pick32());
	endtask

	// Load a random set of gains; unless extreme is set, small magnitudes keep state from pinning.
	task automatic load_random_gains(input bit extreme);
		for (int i = 0; i < 8; i++) begin
			logic [63:0] v;
			if (extreme) v = {pick32(), pick32()};
			else v = {32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000),
				32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000)};
			write_reg(i[2:0], v);
		end
		cfg_we <= 0;
	endtask

	initial begin
		foreach (hot_cells[i]) hot_cells[i] = 12'($urandom);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset gains, extremes of every field, axis three, far cells.
		send_item(0, 0, 32'h7FFFFFFF, 0, 0, 0, 0);
		send_item(4095, 2, 32'h80000000, 0, 0, 0, 0);
		send_item(7, 3, 32'h01000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000);
		start <= 0;
		drain();
		write_reg(REG_E_GAIN, 64'h0000_0000_1000_0000);
		write_reg(REG_CURL_GAIN, 64'h0000_0000_7FFF_FFFF);
		write_reg(REG_CURRENT_GAIN, 64'h0000_0000_0800_0000);
		write_reg(REG_POLAR_GAIN, 64'h0000_0000_F800_0000);
		write_reg(REG_PREV_POLAR_GAIN, 64'h0000_0000_0400_0000);
		write_reg(REG_DRUDE_PAIR, 64'h0E00_0000_0100_0000);
		write_reg(REG_LORENTZ_DRIVE, 64'h0000_0000_0080_0000);
		write_reg(REG_LORENTZ_PAIR, 64'h1800_0000_0C00_0000);
		cfg_we <= 0;
		for (int k = 0; k < 6; k++) send_item(5, 1, 32'h0100_0000 << k[1:0],
			32'h0200_0000, 32'hFF00_0000, 32'h1000_0000, 32'h8000_0000);
		send_item(5, 3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF);
		send_item(5, 2, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000);
		send_item(4095, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF);
		start <= 0;
		drain();

		// Random phases, each with its own gains and idling.
		for (int ph = 0; ph < 6; ph++) begin
			load_random_gains(ph == 2 || ph == 5);
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 60;
				2: idle_pct = 25;
				default: idle_pct = 60;
			endcase
			for (int n = 0; n < 85; n++) send_random();
			start <= 0;
			drain();
		end

		// Finish with the register extremes.
		for (int i = 0; i < 8; i++) write_reg(i[2:0], 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_we <= 0;
		for (int n = 0; n < 10; n++) send_random();
		start <= 0;
		drain();
		for (int i = 0; i < 8; i++) write_reg(i[2:0], 64'h7FFF_FFFF_8000_0000);
		cfg_we <= 0;
		for (int n = 0; n < 10; n++) send_random();
		start <= 0;
		drain();

		if (board.errors == 0 && board.pending_e.size() == 0)
			$display("** drude_lorentz_efield_update_unit: PASSED **");
		else
			$display("** drude_lorentz_efield_update_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/dleu_pkg.sv
design/dleu_ram.sv
design/drude_lorentz_efield_update_unit.sv
tb/drude_lorentz_efield_update_unit_test.sv
